/* rtl/core/qpu_pkg.sv */
// ----------------------------------------------------------------------------
// qpu_pkg
// Types and constants shared by the quaternion pack / unpack pipeline.
// ----------------------------------------------------------------------------
package qpu_pkg;

  // command codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // field layout of the packed word
  localparam int X_W  = 22;
  localparam int YZ_W = 21;

  // magnitude constants at scale 2^42 (unit squared) and its tolerance
  localparam logic [44:0] ONE_SQ = 45'h400_0000_0000;
  localparam logic [44:0] TOL_SQ = 45'h000_0040_0000;

  // radicand width (whole bit pairs) and root width
  localparam int RAD_W  = 46;
  localparam int ROOT_W = 23;
  localparam int REM_W  = 25;

  // number of square-root steps, one root bit each
  localparam int SQRT_STEPS = ROOT_W;

  // what every stage carries: the command and the word (encoded or packed input)
  typedef struct packed {
    logic        cmd;
    logic [63:0] word;
  } qpu_base_t;

  // front stage after the squares
  typedef struct packed {
    qpu_base_t   base;
    logic [42:0] sq_x;
    logic [42:0] sq_y;
    logic [42:0] sq_z;
  } qpu_sqr_t;

  // square-root stage payload
  typedef struct packed {
    qpu_base_t         base;
    logic              bad;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } qpu_sq_t;

  // finished item, as held for the output side
  typedef struct packed {
    qpu_base_t         base;
    logic              bad;
    logic [ROOT_W-1:0] root;
  } qpu_res_t;

endpackage

/* rtl/core/qpu_front.sv */
// ----------------------------------------------------------------------------
// qpu_front
// Encode, field squares and magnitude check: three register stages.
// ----------------------------------------------------------------------------
module qpu_front
  import qpu_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic               cmd,
  input  logic        [63:0] packed_in,
  input  logic signed [23:0] w_in,
  input  logic signed [23:0] x_in,
  input  logic signed [23:0] y_in,
  input  logic signed [23:0] z_in,
  output qpu_sq_t            sq_o
);

  qpu_base_t   a_r, a_nxt;
  qpu_sqr_t    b_r, b_nxt;
  qpu_sq_t     c_nxt;
  qpu_sq_t     c_r;

  logic [23:0] xt, yt, zt;
  logic [23:0] xf, yf, zf;
  logic signed [21:0] xs, ys, zs;
  logic signed [43:0] px, py, pz;
  logic [44:0] sum;
  logic [44:0] diff;
  logic        near_one;
  logic        above;

  // stage A: truncate toward zero, flip on negative w, pack
  always_comb begin
    xt = 24'(x_in + 24'(x_in[23])) >>> 1;
    yt = 24'(y_in + (y_in[23] ? 24'sd3 : 24'sd0)) >>> 2;
    zt = 24'(z_in + (z_in[23] ? 24'sd3 : 24'sd0)) >>> 2;
    xt = {xt[22], xt[22:0]};
    yt = {{2{yt[21]}}, yt[21:0]};
    zt = {{2{zt[21]}}, zt[21:0]};
    if (w_in[23]) begin
      xf = 24'(~xt + 24'd1);
      yf = 24'(~yt + 24'd1);
      zf = 24'(~zt + 24'd1);
    end else begin
      xf = xt;
      yf = yt;
      zf = zt;
    end
    a_nxt.cmd  = cmd;
    a_nxt.word = (cmd == CMD_DECODE) ? packed_in
                                     : {xf[X_W-1:0], yf[YZ_W-1:0], zf[YZ_W-1:0]};
  end

  // stage B: squares of the fields at common scale 2^-21
  always_comb begin
    xs = a_r.word[63:42];
    ys = {a_r.word[41:21], 1'b0};
    zs = {a_r.word[20:0], 1'b0};
    px = xs * xs;
    py = ys * ys;
    pz = zs * zs;
    b_nxt.base = a_r;
    b_nxt.sq_x = px[42:0];
    b_nxt.sq_y = py[42:0];
    b_nxt.sq_z = pz[42:0];
  end

  // stage C: magnitude, tolerance band, radicand for the root
  always_comb begin
    sum      = 45'(b_r.sq_x) + 45'(b_r.sq_y) + 45'(b_r.sq_z);
    near_one = (sum > (ONE_SQ - TOL_SQ)) && (sum < (ONE_SQ + TOL_SQ));
    above    = sum >= (ONE_SQ + TOL_SQ);
    diff     = ONE_SQ - sum;
    c_nxt.base = b_r.base;
    c_nxt.rem  = '0;
    c_nxt.root = '0;
    if (b_r.base.cmd == CMD_DECODE && !near_one && !above) begin
      c_nxt.bad = 1'b0;
      c_nxt.rad = {diff[43:0], 2'b00};
    end else begin
      c_nxt.bad = (b_r.base.cmd == CMD_DECODE) && above;
      c_nxt.rad = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

  assign sq_o = c_r;

endmodule

/* rtl/core/qpu_sqrt_step.sv */
// ----------------------------------------------------------------------------
// qpu_sqrt_step
// One restoring square-root step: take two radicand bits, settle one root bit.
// ----------------------------------------------------------------------------
module qpu_sqrt_step
  import qpu_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  qpu_sq_t d,
  output qpu_sq_t q
);

  qpu_sq_t          q_r, q_nxt;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;

  always_comb begin
    rem_sh = {d.rem, d.rad[RAD_W-1 -: 2]};
    trial  = (REM_W+2)'({d.root, 2'b01});
    q_nxt      = d;
    q_nxt.rad  = {d.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      q_nxt.rem  = REM_W'(rem_sh - trial);
      q_nxt.root = {d.root[ROOT_W-2:0], 1'b1};
    end else begin
      q_nxt.rem  = rem_sh[REM_W-1:0];
      q_nxt.root = {d.root[ROOT_W-2:0], 1'b0};
    end
  end

  // advance with the pipe
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* rtl/core/quaternion_pack_unpack_64.sv */
// Three front stages and 23 root stages lie between input accept and out_tvalid.
// One item per cycle while the skid register is empty; the root chain settles one bit per stage.
// A stalled output parks its item in a skid register; input ready drops only while
// that register is full.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_pack_unpack_64
// Packs a unit quaternion into 64 bits (w dropped) or unpacks it, rebuilding w
// with a pipelined integer square root.
// ----------------------------------------------------------------------------
module quaternion_pack_unpack_64
  import qpu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, low to high: packed_in[63:0], w_in[87:64], x_in[111:88],
  //                        y_in[135:112], z_in[159:136]
  input  logic [159:0] in_tdata,
  // in_tuser: command (0 encode, 1 decode)
  input  logic         in_tuser,
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, low to high: packed_out[63:0], w_out[86:64], x_out[108:87],
  //                         y_out[131:109], z_out[154:132], zero pad[159:155]
  output logic [159:0] out_tdata,
  // out_tuser: w_invalid
  output logic         out_tuser
);

  localparam int NSTG = 3 + SQRT_STEPS;

  logic            en;
  logic [NSTG-1:0] v_r;
  qpu_sq_t         sq [0:SQRT_STEPS];
  qpu_res_t        last;
  qpu_res_t        skid_r;
  logic            skid_v_r, skid_v_nxt;
  qpu_res_t        res;

  // the whole pipe moves together whenever the skid register is empty
  assign en        = !skid_v_r;
  assign in_tready = en;

  qpu_front u_front (
    .clk       (clk),
    .en        (en),
    .cmd       (in_tuser),
    .packed_in (in_tdata[63:0]),
    .w_in      (in_tdata[87:64]),
    .x_in      (in_tdata[111:88]),
    .y_in      (in_tdata[135:112]),
    .z_in      (in_tdata[159:136]),
    .sq_o      (sq[0])
  );

  // one root bit per stage, most significant first
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
    qpu_sqrt_step u_step (
      .clk (clk),
      .en  (en),
      .d   (sq[k]),
      .q   (sq[k+1])
    );
  end

  // valid bits travel with the data; bubbles move along too
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_tvalid};
    end
  end

  always_comb begin
    last.base = sq[SQRT_STEPS].base;
    last.bad  = sq[SQRT_STEPS].bad;
    last.root = sq[SQRT_STEPS].root;
  end

  // park the last stage's item when the pipe moves on and the sink is stalled;
  // drain the parked item first once the sink takes it
  always_comb begin
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (out_tready) begin
        skid_v_nxt = 1'b0;
      end
    end else if (v_r[NSTG-1] && !out_tready) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_r <= last;
    end
  end

  assign res        = skid_v_r ? skid_r : last;
  assign out_tvalid = skid_v_r || v_r[NSTG-1];

  // format the result: encode shows only the packed word, decode only the fields
  always_comb begin
    out_tdata = '0;
    out_tuser = 1'b0;
    if (res.base.cmd == CMD_DECODE) begin
      out_tdata[86:64]   = res.root;
      out_tdata[108:87]  = res.base.word[63:42];
      out_tdata[131:109] = {res.base.word[41:21], 2'b00};
      out_tdata[154:132] = {res.base.word[20:0], 2'b00};
      out_tuser          = res.bad;
    end else begin
      out_tdata[63:0]    = res.base.word;
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams encode and decode items through quaternion_pack_unpack_64 with
// random gaps on the input and random stalls on the output, and checks every
// result item against a predictor kept in this file.
// ----------------------------------------------------------------------------
module testbench
  import qpu_pkg::*;
();

  // run length and timing
  localparam int RANDOM_ITEMS = 1700;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;

  // unit magnitude at scale 2^42 and the band around it that counts as one
  localparam longint UNIT_MAG = 64'd1 << 42;
  localparam longint UNIT_BAND = 64'd1 << 22;

  // one input item as the sender holds it
  typedef struct {
    logic               cmd;
    logic        [63:0] packed_in;
    logic signed [23:0] w_in;
    logic signed [23:0] x_in;
    logic signed [23:0] y_in;
    logic signed [23:0] z_in;
    bit                 drain;        // hold until every result is back
  } quat_req_t;

  // one result item
  typedef struct {
    logic [63:0] packed_out;
    logic [22:0] w_out;
    logic [21:0] x_out;
    logic [22:0] y_out;
    logic [22:0] z_out;
    logic        w_invalid;
  } quat_res_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic         out_tuser;

  quat_req_t pending_reqs[$];
  quat_res_t expected_res[$];
  quat_req_t req_on_bus;
  int        reqs_sent = 0;
  int        res_seen = 0;
  int        fail_cnt = 0;
  int        cycle_cnt = 0;
  int        gap_left = 0;
  int        calm_left = 0;
  int        ready_hold = 0;

  quaternion_pack_unpack_64 i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Floor of the square root, built one root bit at a time from the top.
  function automatic longint root_floor(longint n);
    longint r;
    longint c;
    r = 0;
    for (int b = 22; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // Work out the result item that one input item must produce.
  function automatic quat_res_t convert_quat(quat_req_t req);
    quat_res_t res;
    longint    wv, xv, yv, zv;
    longint    xb, yb, zb, ys, zs, mag, off_unit, yq, zq, root;
    res = '{default: '0};
    if (req.cmd == CMD_ENCODE) begin
      // halve x and quarter y, z, truncating toward zero
      wv = req.w_in;
      xv = req.x_in;
      yv = req.y_in;
      zv = req.z_in;
      xv = xv / 2;
      yv = yv / 4;
      zv = zv / 4;
      // flip to the hemisphere with w >= 0
      if (wv < 0) begin
        xv = -xv;
        yv = -yv;
        zv = -zv;
      end
      res.packed_out = {xv[21:0], yv[20:0], zv[20:0]};
    end else begin
      xb = $signed(req.packed_in[63:42]);
      yb = $signed(req.packed_in[41:21]);
      zb = $signed(req.packed_in[20:0]);
      // bring y, z to the scale of x (2^-21) before squaring
      ys = yb * 2;
      zs = zb * 2;
      mag = xb * xb + ys * ys + zs * zs;
      off_unit = (mag >= UNIT_MAG) ? mag - UNIT_MAG : UNIT_MAG - mag;
      if (off_unit < UNIT_BAND) begin
        res.w_out = '0;
      end else if (mag > UNIT_MAG) begin
        res.w_invalid = 1'b1;
      end else begin
        root = root_floor((UNIT_MAG - mag) * 4);
        res.w_out = root[22:0];
      end
      yq = yb * 4;
      zq = zb * 4;
      res.x_out = xb[21:0];
      res.y_out = yq[22:0];
      res.z_out = zq[22:0];
    end
    return res;
  endfunction

  // Pack three decode fields into a word, x on top.
  function automatic logic [63:0] qword(int xf, int yf, int zf);
    return {xf[21:0], yf[20:0], zf[20:0]};
  endfunction

  // Queue an encode item; fill the unused word with noise.
  task automatic queue_encode(int w, int x, int y, int z);
    quat_req_t req;
    req.cmd = CMD_ENCODE;
    req.packed_in = {$urandom, $urandom};
    req.w_in = w[23:0];
    req.x_in = x[23:0];
    req.y_in = y[23:0];
    req.z_in = z[23:0];
    req.drain = 1'b0;
    pending_reqs.push_back(req);
  endtask

  // Queue a decode item; fill the unused components with noise.
  task automatic queue_decode(logic [63:0] word);
    quat_req_t req;
    req.cmd = CMD_DECODE;
    req.packed_in = word;
    req.w_in = $urandom;
    req.x_in = $urandom;
    req.y_in = $urandom;
    req.z_in = $urandom;
    req.drain = 1'b0;
    pending_reqs.push_back(req);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Sender: present the head of the pending queue, hold it until accepted,
  // and record the expected result the moment the handshake completes.
  always @(posedge clk) begin
    int roll;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_res.push_back(convert_quat(req_on_bus));
        reqs_sent++;
        // pick the idle time before the next item
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 2) calm_left = $urandom_range(20, 80);
          if (roll < 55) gap_left = 0;
          else if (roll < 90) gap_left = $urandom_range(1, 3);
          else gap_left = $urandom_range(8, 40);
        end
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain || reqs_sent == res_seen)) begin
          req_on_bus = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= req_on_bus.cmd;
          in_tdata <= {req_on_bus.z_in, req_on_bus.y_in, req_on_bus.x_in,
                       req_on_bus.w_in, req_on_bus.packed_in};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: alternate runs of ready and stall, mostly short stalls,
  // a few long ones, and now and then a long run with no stall at all.
  always @(posedge clk) begin
    int roll;
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (ready_hold == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          out_tready <= 1'b1;
          ready_hold = $urandom_range(100, 300);
        end else if (roll < 60) begin
          out_tready <= 1'b1;
          ready_hold = $urandom_range(1, 40);
        end else if (roll < 90) begin
          out_tready <= 1'b0;
          ready_hold = $urandom_range(1, 3);
        end else begin
          out_tready <= 1'b0;
          ready_hold = $urandom_range(8, 40);
        end
      end
      ready_hold--;
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    quat_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      res_seen <= res_seen + 1;
      if (expected_res.size() == 0) begin
        $error("result item with no expectation waiting: tdata 0x%0h", out_tdata);
        fail_cnt++;
      end else begin
        want = expected_res.pop_front();
        check_field("packed_out", want.packed_out, out_tdata[63:0]);
        check_field("w_out", want.w_out, out_tdata[86:64]);
        check_field("x_out", want.x_out, out_tdata[108:87]);
        check_field("y_out", want.y_out, out_tdata[131:109]);
        check_field("z_out", want.z_out, out_tdata[154:132]);
        check_field("w_invalid", want.w_invalid, out_tuser);
      end
    end
  end

  // Watchdog: stop a run that hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int mode;
    int sign;

    // directed encodes: zero, extremes, hemisphere flip, truncation, a real rotation
    queue_encode(0, 0, 0, 0);
    queue_encode(0, 8388607, 8388607, 8388607);
    queue_encode(-8388608, -8388608, -8388608, -8388608);
    queue_encode(-1, 3, 5, 7);
    queue_encode(0, -3, -7, -5);
    queue_encode(8388607, -8388608, 8388607, -1);
    queue_encode(-2965821, 2965821, 0, 0);
    queue_encode(2965821, 0, -2965821, 1);

    // directed decodes: identity, all ones, around the unit band, beyond one
    queue_decode(64'h0);
    queue_decode(64'hFFFF_FFFF_FFFF_FFFF);
    queue_decode(qword(2097151, 0, 0));          // just inside the band
    queue_decode(qword(-2097152, 0, 0));         // exactly one
    queue_decode(qword(-2097152, 0, 1024));      // band edge above one: invalid
    queue_decode(qword(-2097152, 0, 1023));      // inside the band above one
    queue_decode(qword(2097150, 0, 0));          // just outside, small root
    queue_decode(qword(2097151, 1048575, 1048575));
    queue_decode(qword(-2097152, -1048576, -1048576));
    queue_decode(qword(1048576, 524288, 0));
    queue_decode(qword(0, -1048576, 0));         // y alone reaching one

    // random part: half encodes, half decodes weighted toward the unit sphere
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 9) < 7) begin
          queue_encode($urandom, $urandom, $urandom, $urandom);
        end else begin
          queue_encode(int'($urandom_range(0, 8388608)) - 4194304,
                       int'($urandom_range(0, 8388608)) - 4194304,
                       int'($urandom_range(0, 8388608)) - 4194304,
                       int'($urandom_range(0, 8388608)) - 4194304);
        end
      end else begin
        mode = $urandom_range(0, 99);
        if (mode < 25) begin
          queue_decode({$urandom, $urandom});
        end else if (mode < 70) begin
          queue_decode(qword(int'($urandom_range(0, 2097152)) - 1048576,
                             int'($urandom_range(0, 1048576)) - 524288,
                             int'($urandom_range(0, 1048576)) - 524288));
        end else begin
          // near the unit sphere: x close to one, y and z tiny
          sign = $urandom_range(0, 1) ? 1 : -1;
          queue_decode(qword(sign * (2097152 - int'($urandom_range(0, 4096))),
                             int'($urandom_range(0, 4096)) - 2048,
                             int'($urandom_range(0, 4096)) - 2048));
        end
      end
      // now and then hold the sender until the pipeline has drained
      if (n == 300 || n == 900 || n == 1500)
        pending_reqs[pending_reqs.size() - 1].drain = 1'b1;
    end

    // reset, released on a clock edge
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // wait until every item is sent and every result is back
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() != 0 || in_tvalid || expected_res.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;
    if (expected_res.size() != 0) begin
      $error("%0d expected result items never arrived", expected_res.size());
      fail_cnt++;
    end

    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
